// ===== src/rv64_integer_execute_unit_defines.svh =====
// Assertion helpers shared by the execute unit.
`ifndef RV64_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define RV64_INTEGER_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define RV64IE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rv64ie assertion failed");

// Next-cycle implication, checked on clk, off during reset.
`define RV64IE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rv64ie assertion failed");

`endif

// ===== src/rv64ie_pkg.sv =====
package rv64ie_pkg;

	localparam int XLEN    = 64;
	localparam int NREGS   = 32;
	localparam int REG_AW  = 5;
	localparam int CODE_W  = 10;

	localparam logic [CODE_W-1:0] CODE_ADD  = 10'h000;
	localparam logic [CODE_W-1:0] CODE_SUB  = 10'h100;
	localparam logic [CODE_W-1:0] CODE_SLL  = 10'h001;
	localparam logic [CODE_W-1:0] CODE_SLT  = 10'h002;
	localparam logic [CODE_W-1:0] CODE_SLTU = 10'h003;
	localparam logic [CODE_W-1:0] CODE_XOR  = 10'h004;
	localparam logic [CODE_W-1:0] CODE_SRL  = 10'h005;
	localparam logic [CODE_W-1:0] CODE_SRA  = 10'h105;
	localparam logic [CODE_W-1:0] CODE_OR   = 10'h006;
	localparam logic [CODE_W-1:0] CODE_AND  = 10'h007;

	localparam logic OP_REG = 1'b0;
	localparam logic OP_JAL = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] instr;
	} item_t;

	typedef struct packed {
		logic              wrote;
		logic [REG_AW-1:0] dest_index;
		logic [XLEN-1:0]   dest_value;
		logic [XLEN-1:0]   next_pc;
		logic              unsupported;
	} result_t;

endpackage

// ===== src/rv64ie_ram.sv =====
module rv64ie_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== src/rv64_integer_execute_unit.sv =====
// RV64 integer execute unit: takes one transaction per cycle (register-register ALU op or JAL)
// and returns one result per transaction after a read stage and an execute stage. The first
// stage reads both source registers from a two-read, one-write register file RAM; the second
// executes, writes the destination back and updates the program counter. A result written
// in the execute cycle is forwarded to the transaction reading behind it, so back-to-back
// dependent instructions run at full rate. Per-entry valid flops make the register file
// read as zero after reset with no clearing pass. A stalled output holds the execute stage
// and stalls the input.
`include "rv64_integer_execute_unit_defines.svh"

module rv64_integer_execute_unit import rv64ie_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic              accept;
	logic              s1_adv;
	logic [REG_AW-1:0] rs1_in;
	logic [REG_AW-1:0] rs2_in;

	logic              v_s1;
	logic              op_s1;
	logic [31:0]       instr_s1;
	logic              rs1_fwd_s1;
	logic              rs2_fwd_s1;
	logic              rs1_vld_s1;
	logic              rs2_vld_s1;
	logic [XLEN-1:0]   fwd_val_s1;

	logic [XLEN-1:0]   pc_q;
	logic [NREGS-1:0]  vld_q;
	logic              out_v_q;
	result_t           result_q;

	logic [XLEN-1:0]   ram_a;
	logic [XLEN-1:0]   ram_b;
	result_t           res_c;

	assign rs1_in = item.instr[19:15];
	assign rs2_in = item.instr[24:20];

	assign s1_adv       = v_s1 && (!out_v_q || !result_stall);
	assign item_stall   = v_s1 && !s1_adv;
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_v_q;
	assign result       = result_q;

	rv64ie_ram #(
		.WIDTH(XLEN),
		.DEPTH(NREGS)
	) u_regfile (
		.clk    (clk),
		.we     (s1_adv && res_c.wrote),
		.waddr  (res_c.dest_index),
		.wdata  (res_c.dest_value),
		.re     (accept),
		.raddr_a(rs1_in),
		.raddr_b(rs2_in),
		.rdata_a(ram_a),
		.rdata_b(ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
			pc_q    <= '0;
			vld_q   <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
				pc_q    <= res_c.next_pc;
				if (res_c.wrote) begin
					vld_q[res_c.dest_index] <= 1'b1;
				end
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= item.op;
			instr_s1   <= item.instr;
			rs1_fwd_s1 <= v_s1 && res_c.wrote && (res_c.dest_index == rs1_in);
			rs2_fwd_s1 <= v_s1 && res_c.wrote && (res_c.dest_index == rs2_in);
			rs1_vld_s1 <= vld_q[rs1_in];
			rs2_vld_s1 <= vld_q[rs2_in];
			fwd_val_s1 <= res_c.dest_value;
		end
		if (s1_adv) begin
			result_q <= res_c;
		end
	end

	always_comb begin
		logic [XLEN-1:0]   a;
		logic [XLEN-1:0]   b;
		logic [5:0]        sh;
		logic [XLEN-1:0]   imm;
		logic [XLEN-1:0]   val;
		logic              have;
		logic              bad;
		logic [REG_AW-1:0] rd;

		a    = rs1_fwd_s1 ? fwd_val_s1 : (rs1_vld_s1 ? ram_a : '0);
		b    = rs2_fwd_s1 ? fwd_val_s1 : (rs2_vld_s1 ? ram_b : '0);
		sh   = b[5:0];
		imm  = {{43{instr_s1[31]}}, instr_s1[31], instr_s1[19:12], instr_s1[20],
			instr_s1[30:21], 1'b0};
		rd   = instr_s1[11:7];
		val  = '0;
		have = 1'b1;
		bad  = 1'b0;
		res_c.next_pc = pc_q + XLEN'(4);
		if (op_s1 == OP_JAL) begin
			val           = pc_q + XLEN'(4);
			res_c.next_pc = pc_q + imm;
		end else begin
			case ({instr_s1[31:25], instr_s1[14:12]})
				CODE_ADD:  val = a + b;
				CODE_SUB:  val = a - b;
				CODE_SLL:  val = a << sh;
				CODE_SLT:  val = XLEN'($signed(a) < $signed(b));
				CODE_SLTU: val = XLEN'(a < b);
				CODE_XOR:  val = a ^ b;
				CODE_SRL:  val = a >> sh;
				CODE_SRA:  val = XLEN'($signed(a) >>> sh);
				CODE_OR:   val = a | b;
				CODE_AND:  val = a & b;
				default: begin
					have = 1'b0;
					bad  = 1'b1;
				end
			endcase
		end
		res_c.wrote       = have && (rd != '0);
		res_c.dest_index  = res_c.wrote ? rd : '0;
		res_c.dest_value  = res_c.wrote ? val : '0;
		res_c.unsupported = bad;
	end

	`RV64IE_ASSERT_IMP(a_no_x0_write, s1_adv && res_c.wrote, res_c.dest_index != '0)
	`RV64IE_ASSERT_IMP(a_stall_cause, item_stall, v_s1 && out_v_q && result_stall)
	`RV64IE_ASSERT_IMP(a_bad_no_write, out_v_q && result_q.unsupported, !result_q.wrote)
	`RV64IE_ASSERT_NEXT(a_pc_update, s1_adv, pc_q == $past(res_c.next_pc))
	`RV64IE_ASSERT_NEXT(a_vld_set, s1_adv && res_c.wrote, vld_q[$past(res_c.dest_index)])

endmodule

// ===== verif/tb_rv64_integer_execute_unit.sv =====
`timescale 1ns / 100ps

module tb_rv64_integer_execute_unit;
	import rv64ie_pkg::*;

	localparam logic [6:0] OPC_OP  = 7'h33;
	localparam logic [6:0] OPC_JAL = 7'h6F;
	localparam int RANDOM_ITEMS   = 1250;
	localparam int DRAIN_AT       = 600;
	localparam int HOLD_AT_A      = 300;
	localparam int HOLD_AT_B      = 1500;
	localparam int HOLD_LEN       = 100;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_PRINTED    = 40;

	typedef struct {
		item_t it;
		bit    drain;
	} pending_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item_data = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_data;
	logic    hold_on = 1'b0;

	pending_t pend_q[$];
	result_t  retire_q[$];

	logic [XLEN-1:0] arch_regs [NREGS] = '{default: '0};
	logic [XLEN-1:0] arch_pc = '0;

	int n_pred;
	int n_done;
	int mismatches = 0;
	int idle_cycles = 0;
	int tx_gap;
	int tx_quiet_left;
	int rx_cycle;
	int rx_stall_left;
	int rx_free_left;
	int rx_hold_left;

	rv64_integer_execute_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report(string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// mostly short, a few long
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CODE_W-1:0] alu_code(int idx);
		case (idx)
			0: return CODE_ADD;
			1: return CODE_SUB;
			2: return CODE_SLL;
			3: return CODE_SLT;
			4: return CODE_SLTU;
			5: return CODE_XOR;
			6: return CODE_SRL;
			7: return CODE_SRA;
			8: return CODE_OR;
			default: return CODE_AND;
		endcase
	endfunction

	function automatic item_t make_alu(logic [CODE_W-1:0] code, logic [4:0] rd,
		logic [4:0] rs1, logic [4:0] rs2);
		item_t it;
		it.op = OP_REG;
		it.instr = {code[9:3], rs2, rs1, code[2:0], rd, OPC_OP};
		return it;
	endfunction

	function automatic item_t make_jal(logic [4:0] rd, logic [20:0] imm);
		item_t it;
		it.op = OP_JAL;
		it.instr = {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		logic [CODE_W-1:0] code;
		int r;
		r = $urandom_range(0, 99);
		it.instr = $urandom;
		if (r < 25) begin
			it.op = OP_JAL;
			it.instr[6:0] = OPC_JAL;
		end else if (r < 88) begin
			code = alu_code($urandom_range(0, 9));
			it.op = OP_REG;
			it.instr[31:25] = code[9:3];
			it.instr[14:12] = code[2:0];
			it.instr[6:0] = OPC_OP;
		end else begin
			it.op = 1'($urandom_range(0, 1));
		end
		return it;
	endfunction

	// architectural state update and expected writeback
	function automatic result_t execute_model(item_t it);
		result_t res;
		logic [XLEN-1:0] a, b, val, imm;
		logic [CODE_W-1:0] code;
		logic [REG_AW-1:0] rd;
		logic [5:0] sh;
		logic have;
		res = '0;
		rd = it.instr[11:7];
		code = {it.instr[31:25], it.instr[14:12]};
		a = arch_regs[it.instr[19:15]];
		b = arch_regs[it.instr[24:20]];
		sh = b[5:0];
		have = 1'b1;
		val = '0;
		if (it.op == OP_REG) begin
			case (code)
				CODE_ADD:  val = a + b;
				CODE_SUB:  val = a - b;
				CODE_SLL:  val = a << sh;
				CODE_SLT:  val = ($signed(a) < $signed(b)) ? XLEN'(1) : '0;
				CODE_SLTU: val = (a < b) ? XLEN'(1) : '0;
				CODE_XOR:  val = a ^ b;
				CODE_SRL:  val = a >> sh;
				CODE_SRA:  val = $signed(a) >>> sh;
				CODE_OR:   val = a | b;
				CODE_AND:  val = a & b;
				default: begin
					have = 1'b0;
					res.unsupported = 1'b1;
				end
			endcase
			arch_pc = arch_pc + XLEN'(4);
		end else begin
			imm = {{43{it.instr[31]}}, it.instr[31], it.instr[19:12], it.instr[20],
				it.instr[30:21], 1'b0};
			val = arch_pc + XLEN'(4);
			arch_pc = arch_pc + imm;
		end
		if (have && rd != '0) begin
			arch_regs[rd] = val;
			res.wrote = 1'b1;
			res.dest_index = rd;
			res.dest_value = val;
		end
		res.next_pc = arch_pc;
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item_data <= '0;
			n_pred = 0;
			tx_gap = 0;
			tx_quiet_left = 0;
		end else begin
			if (item_valid && !item_stall) begin
				retire_q.push_back(execute_model(item_data));
				n_pred++;
			end
			if (!item_valid || !item_stall) begin
				if (tx_gap > 0 && !hold_on) begin
					tx_gap--;
					item_valid <= 1'b0;
				end else if (pend_q.size() == 0) begin
					item_valid <= 1'b0;
				end else if (pend_q[0].drain && n_pred != n_done) begin
					item_valid <= 1'b0;
				end else begin
					item_data <= pend_q[0].it;
					item_valid <= 1'b1;
					void'(pend_q.pop_front());
					if (tx_quiet_left > 0) begin
						tx_quiet_left--;
						tx_gap = 0;
					end else begin
						tx_gap = gap_length();
						if ($urandom_range(0, 29) == 0) tx_quiet_left = $urandom_range(30, 90);
					end
				end
			end
		end
	end

	// receiver backpressure, with two long hold-offs that fill the pipe
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_on <= 1'b0;
			rx_cycle = 0;
			rx_stall_left = 0;
			rx_free_left = 0;
			rx_hold_left = 0;
		end else begin
			rx_cycle++;
			if (rx_cycle == HOLD_AT_A || rx_cycle == HOLD_AT_B) rx_hold_left = HOLD_LEN;
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				result_stall <= 1'b1;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				result_stall <= 1'b1;
			end else if (rx_free_left > 0) begin
				rx_free_left--;
				result_stall <= 1'b0;
			end else begin
				rx_stall_left = gap_length();
				rx_free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
					: $urandom_range(1, 6);
				result_stall <= 1'b0;
			end
			hold_on <= (rx_hold_left > 0);
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			n_done <= 0;
		end else if (result_valid && !result_stall) begin
			n_done <= n_done + 1;
			if (retire_q.size() == 0) begin
				report($sformatf("result with no transaction pending, next_pc %h",
					result_data.next_pc));
			end else begin
				want = retire_q.pop_front();
				if (result_data.wrote !== want.wrote)
					report($sformatf("#%0d wrote %b, want %b", n_done,
						result_data.wrote, want.wrote));
				if (result_data.dest_index !== want.dest_index)
					report($sformatf("#%0d dest_index %0d, want %0d", n_done,
						result_data.dest_index, want.dest_index));
				if (result_data.dest_value !== want.dest_value)
					report($sformatf("#%0d dest_value %h, want %h", n_done,
						result_data.dest_value, want.dest_value));
				if (result_data.next_pc !== want.next_pc)
					report($sformatf("#%0d next_pc %h, want %h", n_done,
						result_data.next_pc, want.next_pc));
				if (result_data.unsupported !== want.unsupported)
					report($sformatf("#%0d unsupported %b, want %b", n_done,
						result_data.unsupported, want.unsupported));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		// directed: jump extremes, every ALU op, x0 destination, unknown codes
		pend_q.push_back('{make_jal(5'd1, 21'h100000), 1'b0});
		pend_q.push_back('{make_jal(5'd2, 21'h0FFFFE), 1'b0});
		pend_q.push_back('{make_jal(5'd0, 21'h000008), 1'b0});
		pend_q.push_back('{make_jal(5'd31, 21'h1FFFFC), 1'b0});
		pend_q.push_back('{make_alu(CODE_ADD, 5'd3, 5'd1, 5'd2), 1'b0});
		pend_q.push_back('{make_alu(CODE_SUB, 5'd4, 5'd0, 5'd1), 1'b0});
		pend_q.push_back('{make_alu(CODE_SLL, 5'd5, 5'd4, 5'd2), 1'b0});
		pend_q.push_back('{make_alu(CODE_SLT, 5'd6, 5'd4, 5'd1), 1'b0});
		pend_q.push_back('{make_alu(CODE_SLTU, 5'd7, 5'd4, 5'd1), 1'b0});
		pend_q.push_back('{make_alu(CODE_XOR, 5'd8, 5'd4, 5'd2), 1'b0});
		pend_q.push_back('{make_alu(CODE_SRL, 5'd9, 5'd4, 5'd31), 1'b0});
		pend_q.push_back('{make_alu(CODE_SRA, 5'd10, 5'd4, 5'd31), 1'b0});
		pend_q.push_back('{make_alu(CODE_OR, 5'd11, 5'd4, 5'd2), 1'b0});
		pend_q.push_back('{make_alu(CODE_AND, 5'd12, 5'd4, 5'd2), 1'b0});
		pend_q.push_back('{make_alu(CODE_SUB, 5'd15, 5'd0, 5'd6), 1'b0});
		pend_q.push_back('{make_alu(CODE_SLL, 5'd16, 5'd4, 5'd15), 1'b0});
		pend_q.push_back('{make_alu(CODE_SRA, 5'd17, 5'd4, 5'd15), 1'b0});
		pend_q.push_back('{make_alu(CODE_SRL, 5'd18, 5'd4, 5'd15), 1'b0});
		pend_q.push_back('{make_alu(CODE_ADD, 5'd0, 5'd1, 5'd2), 1'b0});
		pend_q.push_back('{make_alu(CODE_SUB | CODE_SLL, 5'd20, 5'd1, 5'd2), 1'b0});
		pend_q.push_back('{item_t'{OP_REG, 32'hFFFF_FFFF}, 1'b0});
		pend_q.push_back('{item_t'{OP_REG, 32'h0000_0000}, 1'b0});
		pend_q.push_back('{item_t'{OP_JAL, 32'hFFFF_FFFF}, 1'b0});
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pend_q.push_back('{rand_item(), (i == 0 || i == DRAIN_AT)});
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (pend_q.size() != 0 || item_valid || n_done != n_pred);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (retire_q.size() != 0) report($sformatf("%0d results never came", retire_q.size()));
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/rv64ie_pkg.sv
src/rv64ie_ram.sv
src/rv64_integer_execute_unit.sv
verif/tb_rv64_integer_execute_unit.sv
